// ===== src/console_line_editor_tx_fifo_core_assert.svh =====
// Assertion macros used by the console line editor datapath.
`ifndef CONSOLE_LINE_EDITOR_TX_FIFO_CORE_ASSERT_SVH
`define CONSOLE_LINE_EDITOR_TX_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CLETF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLETF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cletf_pkg.sv =====
`timescale 1ns / 1ps

package cletf_pkg;

  localparam int unsigned RUN_W = 7;

  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_QUEUE = 2'd1;
  localparam logic [1:0] FUNC_PUMP  = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [RUN_W-1:0] MAX_PACKET     = 7'd64;
  localparam logic [RUN_W-1:0] PACKET_CAP_RST = 7'd64;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_TX   = 1'b1;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       usb_connected;
    logic [6:0] accept_count;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EOL,
    OP_ERASE,
    OP_PRINT,
    OP_QUEUE,
    OP_PUMP
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QUEUE,
    ST_EMIT,
    ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    QS_ITEM,
    QS_BS,
    QS_SPACE
  } qsel_e;

  typedef struct packed {
    logic  capture;
    logic  load_line;
    logic  load_tx;
    logic  rd_issue;
    logic  finish;
    logic  erase;
    logic  store_char;
    logic  queue_en;
    qsel_e qsel;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic line_empty;
    logic line_full;
    logic pump_zero;
    logic run_last;
  } dp_stat_t;

endpackage

// ===== src/cletf_ram.sv =====
`timescale 1ns / 1ps

module cletf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cletf_datapath.sv =====
`timescale 1ns / 1ps
`include "console_line_editor_tx_fifo_core_assert.svh"

module cletf_datapath #(
  parameter int unsigned TX_DEPTH   = 2048,
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cletf_pkg::in_t              in_i,
  input  logic                        cfg_we_i,
  input  logic [cletf_pkg::RUN_W-1:0] cfg_data_i,
  input  cletf_pkg::dp_cmd_t          cmd_i,
  output cletf_pkg::dp_stat_t         stat_o,
  output logic                        out_strobe_o,
  output cletf_pkg::out_t             res_o
);

  localparam int unsigned AW  = $clog2(TX_DEPTH);
  localparam int unsigned SW  = ((AW > cletf_pkg::RUN_W) ? AW : cletf_pkg::RUN_W) + 1;
  localparam int unsigned LAW = $clog2(LINE_DEPTH);
  localparam int unsigned LCW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned RW  = cletf_pkg::RUN_W;

  cletf_pkg::in_t  item_q;
  logic [AW-1:0]   tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [LCW-1:0]  line_count_q, line_count_d;
  logic [RW-1:0]   packet_cap_q;
  logic [RW-1:0]   run_q, idx_q;
  logic            src_q;
  logic            rd_pend_q, rd_last_q, rd_kind_q;

  cletf_pkg::op_e  op;
  logic [AW-1:0]   head_next;
  logic            q_wr;
  logic [7:0]      q_byte;
  logic [SW-1:0]   contig, tail_sum;
  logic [RW-1:0]   cap_eff, run_cap, run_tx;
  logic [AW-1:0]   tx_raddr;
  logic [SW-1:0]   tx_raddr_w;
  logic [7:0]      tx_rdata, line_rdata;

  // Item classification.
  always_comb begin
    op = cletf_pkg::OP_NONE;
    unique case (item_q.func)
      cletf_pkg::FUNC_RX: begin
        unique case (item_q.data_byte) inside
          cletf_pkg::CH_CR, cletf_pkg::CH_LF:         op = cletf_pkg::OP_EOL;
          cletf_pkg::CH_BS, cletf_pkg::CH_DEL:        op = cletf_pkg::OP_ERASE;
          [cletf_pkg::CH_SPACE:cletf_pkg::CH_TILDE]:  op = cletf_pkg::OP_PRINT;
          default:                                    op = cletf_pkg::OP_NONE;
        endcase
      end
      cletf_pkg::FUNC_QUEUE: op = cletf_pkg::OP_QUEUE;
      cletf_pkg::FUNC_PUMP:  op = cletf_pkg::OP_PUMP;
      default:               op = cletf_pkg::OP_NONE;
    endcase
  end

  // Queue byte select and FIFO write.
  always_comb begin
    unique case (cmd_i.qsel)
      cletf_pkg::QS_BS:    q_byte = cletf_pkg::CH_BS;
      cletf_pkg::QS_SPACE: q_byte = cletf_pkg::CH_SPACE;
      default:             q_byte = item_q.data_byte;
    endcase
  end

  assign head_next = (tx_head_q == AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + AW'(1);
  assign q_wr      = cmd_i.queue_en && item_q.usb_connected && (head_next != tx_tail_q);

  // Pump run: contiguous bytes up to head or wrap, then packet cap, then accept count.
  assign contig  = (tx_head_q > tx_tail_q) ? (SW'(tx_head_q) - SW'(tx_tail_q))
                                           : (SW'(TX_DEPTH) - SW'(tx_tail_q));
  assign cap_eff = (packet_cap_q > cletf_pkg::MAX_PACKET) ? cletf_pkg::MAX_PACKET
                                                          : packet_cap_q;
  assign run_cap = (contig > SW'(cap_eff)) ? cap_eff : contig[RW-1:0];
  assign run_tx  = (run_cap > item_q.accept_count) ? item_q.accept_count : run_cap;

  // A run never crosses the wrap point, so tail + idx stays below the depth.
  assign tx_raddr_w = SW'(tx_tail_q) + SW'(idx_q);
  assign tx_raddr   = tx_raddr_w[AW-1:0];
  assign tail_sum   = SW'(tx_tail_q) + SW'(run_q);

  always_comb begin
    tx_head_d = q_wr ? head_next : tx_head_q;
    tx_tail_d = tx_tail_q;
    if (cmd_i.finish && (src_q == cletf_pkg::KIND_TX)) begin
      tx_tail_d = (tail_sum == SW'(TX_DEPTH)) ? '0 : tail_sum[AW-1:0];
    end
  end

  always_comb begin
    line_count_d = line_count_q;
    if (cmd_i.finish && (src_q == cletf_pkg::KIND_LINE)) begin
      line_count_d = '0;
    end else if (cmd_i.erase) begin
      line_count_d = line_count_q - LCW'(1);
    end else if (cmd_i.store_char) begin
      line_count_d = line_count_q + LCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_head_q    <= '0;
      tx_tail_q    <= '0;
      line_count_q <= '0;
      packet_cap_q <= cletf_pkg::PACKET_CAP_RST;
      rd_pend_q    <= 1'b0;
    end else begin
      tx_head_q    <= tx_head_d;
      tx_tail_q    <= tx_tail_d;
      line_count_q <= line_count_d;
      rd_pend_q    <= cmd_i.rd_issue;
      if (cfg_we_i) begin
        packet_cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_i;
    end
    if (cmd_i.load_line) begin
      run_q <= RW'(line_count_q);
      src_q <= cletf_pkg::KIND_LINE;
      idx_q <= '0;
    end else if (cmd_i.load_tx) begin
      run_q <= run_tx;
      src_q <= cletf_pkg::KIND_TX;
      idx_q <= '0;
    end else if (cmd_i.rd_issue) begin
      idx_q <= idx_q + RW'(1);
    end
    rd_last_q <= (idx_q == run_q - RW'(1));
    rd_kind_q <= src_q;
  end

  cletf_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (q_wr),
    .waddr_i(tx_head_q),
    .wdata_i(q_byte),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  cletf_ram #(
    .WIDTH(8),
    .DEPTH(LINE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.store_char),
    .waddr_i(line_count_q[LAW-1:0]),
    .wdata_i(item_q.data_byte),
    .raddr_i(idx_q[LAW-1:0]),
    .rdata_o(line_rdata)
  );

  assign stat_o.op         = op;
  assign stat_o.line_empty = (line_count_q == '0);
  assign stat_o.line_full  = (line_count_q >= LCW'(LINE_DEPTH));
  assign stat_o.pump_zero  = !item_q.usb_connected || (tx_head_q == tx_tail_q)
                             || (run_tx == '0);
  assign stat_o.run_last   = (idx_q == run_q - RW'(1));

  assign out_strobe_o   = rd_pend_q;
  assign res_o.kind     = rd_kind_q;
  assign res_o.out_byte = (rd_kind_q == cletf_pkg::KIND_TX) ? tx_rdata : line_rdata;
  assign res_o.last     = rd_last_q;

  `CLETF_ASSERT_IMPL(a_head_range, clk_i, rst_ni, 1'b1, SW'(tx_head_q) < SW'(TX_DEPTH), "head out of range")
  `CLETF_ASSERT_IMPL(a_line_range, clk_i, rst_ni, 1'b1, line_count_q <= LCW'(LINE_DEPTH), "line count overflow")
  `CLETF_ASSERT_IMPL(a_read_in_run, clk_i, rst_ni, cmd_i.rd_issue, idx_q < run_q, "read past run")
  `CLETF_ASSERT_NEXT(a_wr_not_full, clk_i, rst_ni, q_wr, tx_head_q != tx_tail_q, "FIFO wrapped onto tail")

endmodule

// ===== src/cletf_ctrl.sv =====
`timescale 1ns / 1ps

module cletf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  cletf_pkg::dp_stat_t stat_i,
  output cletf_pkg::dp_cmd_t  cmd_o,
  output logic                busy_o
);

  cletf_pkg::state_e state_q, state_d;
  logic [1:0]        q_step_q, q_step_d;
  logic              q_multi_q, q_multi_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cletf_pkg::ST_IDLE;
      q_step_q  <= '0;
      q_multi_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      q_step_q  <= q_step_d;
      q_multi_q <= q_multi_d;
    end
  end

  // Next state.
  always_comb begin
    state_d   = state_q;
    q_step_d  = q_step_q;
    q_multi_d = q_multi_q;
    unique case (state_q)
      cletf_pkg::ST_IDLE: begin
        if (start) begin
          state_d = cletf_pkg::ST_DECODE;
        end
      end
      cletf_pkg::ST_DECODE: begin
        q_step_d  = '0;
        q_multi_d = 1'b0;
        state_d   = cletf_pkg::ST_IDLE;
        unique case (stat_i.op)
          cletf_pkg::OP_EOL: begin
            if (!stat_i.line_empty) state_d = cletf_pkg::ST_EMIT;
          end
          cletf_pkg::OP_ERASE: begin
            if (!stat_i.line_empty) begin
              state_d   = cletf_pkg::ST_QUEUE;
              q_multi_d = 1'b1;
            end
          end
          cletf_pkg::OP_PRINT: begin
            if (!stat_i.line_full) state_d = cletf_pkg::ST_QUEUE;
          end
          cletf_pkg::OP_QUEUE: state_d = cletf_pkg::ST_QUEUE;
          cletf_pkg::OP_PUMP: begin
            if (!stat_i.pump_zero) state_d = cletf_pkg::ST_EMIT;
          end
          default: state_d = cletf_pkg::ST_IDLE;
        endcase
      end
      cletf_pkg::ST_QUEUE: begin
        q_step_d = q_step_q + 2'd1;
        if (!q_multi_q || (q_step_q == 2'd2)) begin
          state_d = cletf_pkg::ST_IDLE;
        end
      end
      cletf_pkg::ST_EMIT: begin
        if (stat_i.run_last) state_d = cletf_pkg::ST_DRAIN;
      end
      cletf_pkg::ST_DRAIN: state_d = cletf_pkg::ST_IDLE;
      default:             state_d = cletf_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    cmd_o.qsel = cletf_pkg::QS_ITEM;
    unique case (state_q)
      cletf_pkg::ST_IDLE: cmd_o.capture = start;
      cletf_pkg::ST_DECODE: begin
        cmd_o.load_line  = (stat_i.op == cletf_pkg::OP_EOL) && !stat_i.line_empty;
        cmd_o.erase      = (stat_i.op == cletf_pkg::OP_ERASE) && !stat_i.line_empty;
        cmd_o.store_char = (stat_i.op == cletf_pkg::OP_PRINT) && !stat_i.line_full;
        cmd_o.load_tx    = (stat_i.op == cletf_pkg::OP_PUMP) && !stat_i.pump_zero;
      end
      cletf_pkg::ST_QUEUE: begin
        cmd_o.queue_en = 1'b1;
        if (q_multi_q) begin
          cmd_o.qsel = (q_step_q == 2'd1) ? cletf_pkg::QS_SPACE : cletf_pkg::QS_BS;
        end
      end
      cletf_pkg::ST_EMIT:  cmd_o.rd_issue = 1'b1;
      cletf_pkg::ST_DRAIN: cmd_o.finish   = 1'b1;
      default:             cmd_o          = '0;
    endcase
  end

  assign busy_o = (state_q != cletf_pkg::ST_IDLE);

endmodule

// ===== src/console_line_editor_tx_fifo_core.sv =====
`timescale 1ns / 1ps
// Sequence: a character or queue transaction runs accept, decode, one FIFO write;
//   an erase runs accept, decode and three echo writes. Emission: decode, then one byte per cycle
//   for N bytes from the line or TX RAM, then a drain state that ends the transaction.
// Throughput: one transaction at a time; busy is high from decode to the last result.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset: async active-low; clears head, tail, line count, state; packet_cap returns to 64.

module console_line_editor_tx_fifo_core #(
  parameter int unsigned TX_DEPTH   = 2048,  // TX ring size, holds TX_DEPTH-1 bytes
  parameter int unsigned LINE_DEPTH = 64     // max characters in the edit line
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  cletf_pkg::in_t              in_i,
  // result channel, one byte per strobe
  output logic                        out_strobe_o,
  output cletf_pkg::out_t             res_o,
  // packet_cap write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [cletf_pkg::RUN_W-1:0] cfg_data_i
);

  cletf_pkg::dp_cmd_t  cmd;
  cletf_pkg::dp_stat_t stat;
  logic                busy_int;

  // Controller: sequences decode, echo writes and run emission.
  cletf_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .stat_i(stat),
    .cmd_o (cmd),
    .busy_o(busy_int)
  );

  // Datapath: item register, pointers, line count, both RAMs and the result register.
  cletf_datapath #(
    .TX_DEPTH  (TX_DEPTH),
    .LINE_DEPTH(LINE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_strobe_o(out_strobe_o),
    .res_o       (res_o)
  );

  assign busy        = busy_int;
  // The register is only taken between transactions.
  assign cfg_ready_o = !busy_int;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import cletf_pkg::*;

  // Ring and line sizes match the block's defaults. A directed overlong line
  // covers the full-line corner; random traffic covers the rest.
  localparam int unsigned TX_DEPTH   = 2048;
  localparam int unsigned LINE_DEPTH = 64;

  // func code 3 has no name in the package; the block must ignore it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  in_t             cmd         = '0;
  logic            out_strobe_o;
  out_t            res_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [RUN_W-1:0] cfg_data_i = '0;

  // Tracks the line buffer and the transmit ring, and holds the line and
  // endpoint bytes that accepted commands still owe.
  class console_scoreboard;
    logic [7:0]  tx_ring [TX_DEPTH];
    int unsigned tx_wr;
    int unsigned tx_rd;
    logic [7:0]  line_buf [LINE_DEPTH];
    int unsigned line_len;
    int unsigned pkt_cap;
    out_t        owed_bytes[$];
    int unsigned n_cmds;
    int unsigned n_line_bytes;
    int unsigned n_tx_bytes;
    int unsigned n_drops;
    int unsigned n_line_full;
    int unsigned n_errors;

    function new();
      tx_wr        = 0;
      tx_rd        = 0;
      line_len     = 0;
      pkt_cap      = PACKET_CAP_RST;
      n_cmds       = 0;
      n_line_bytes = 0;
      n_tx_bytes   = 0;
      n_drops      = 0;
      n_line_full  = 0;
      n_errors     = 0;
    endfunction

    function void set_cap(logic [RUN_W-1:0] v);
      pkt_cap = v;
    endfunction

    // one byte into the ring; lost when the link is down or the ring is full
    function void push_tx(logic [7:0] b, logic link);
      int unsigned nxt;
      if (!link) return;
      nxt = (tx_wr + 1) % TX_DEPTH;
      if (nxt == tx_rd) begin
        n_drops++;
        return;
      end
      tx_ring[tx_wr] = b;
      tx_wr = nxt;
    endfunction

    function void note_command(in_t c);
      int unsigned run;
      int unsigned lim;
      int unsigned i;
      n_cmds++;
      case (c.func)
        FUNC_RX: begin
          if (c.data_byte == CH_CR || c.data_byte == CH_LF) begin
            for (i = 0; i < line_len; i++)
              owed_bytes.push_back(out_t'{KIND_LINE, line_buf[i],
                                          (i + 1 == line_len) ? 1'b1 : 1'b0});
            line_len = 0;
          end else if (c.data_byte == CH_BS || c.data_byte == CH_DEL) begin
            if (line_len > 0) begin
              line_len--;
              push_tx(CH_BS, c.usb_connected);
              push_tx(CH_SPACE, c.usb_connected);
              push_tx(CH_BS, c.usb_connected);
            end
          end else if (c.data_byte >= CH_SPACE && c.data_byte <= CH_TILDE) begin
            if (line_len < LINE_DEPTH) begin
              line_buf[line_len] = c.data_byte;
              line_len++;
              push_tx(c.data_byte, c.usb_connected);
            end else begin
              n_line_full++;
            end
          end
        end
        FUNC_QUEUE: push_tx(c.data_byte, c.usb_connected);
        FUNC_PUMP: begin
          if (c.usb_connected && tx_wr != tx_rd) begin
            // contiguous run only: stops at the wrap point
            run = (tx_wr > tx_rd) ? tx_wr - tx_rd : TX_DEPTH - tx_rd;
            lim = (pkt_cap < MAX_PACKET) ? pkt_cap : MAX_PACKET;
            if (run > lim) run = lim;
            if (run > c.accept_count) run = c.accept_count;
            for (i = 0; i < run; i++)
              owed_bytes.push_back(out_t'{KIND_TX, tx_ring[(tx_rd + i) % TX_DEPTH],
                                          (i + 1 == run) ? 1'b1 : 1'b0});
            tx_rd = (tx_rd + run) % TX_DEPTH;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_bytes.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR %0t: unexpected result kind=%0d byte=%02h last=%0d",
                   $realtime, got.kind, got.out_byte, got.last);
        return;
      end
      want = owed_bytes.pop_front();
      if (want.kind == KIND_LINE) n_line_bytes++;
      else n_tx_bytes++;
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.last !== want.last) begin
        n_errors++;
        if (n_errors <= 10)
          $display("ERROR %0t: expected kind=%0d byte=%02h last=%0d, got kind=%0d byte=%02h last=%0d",
                   $realtime, want.kind, want.out_byte, want.last,
                   got.kind, got.out_byte, got.last);
      end
    endfunction
  endclass

  console_scoreboard sb = new();

  console_line_editor_tx_fifo_core #(
    .TX_DEPTH  (TX_DEPTH),
    .LINE_DEPTH(LINE_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (cmd),
    .out_strobe_o(out_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Results cannot be held off: every strobe is one byte, checked at
  // the edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) sb.check_result(res_o);
  end

  function automatic in_t mk_cmd(logic [1:0] f, logic [7:0] b, logic link,
                                 logic [6:0] acc);
    in_t c;
    c.func          = f;
    c.data_byte     = b;
    c.usb_connected = link;
    c.accept_count  = acc;
    return c;
  endfunction

  // Entered at a falling edge; leaves at the falling edge after acceptance
  // with start still high, so back-to-back commands need no second write
  // of start in one step.
  task automatic send_cmd(input in_t c, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    start = 1'b1;
    cmd   = c;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
    @(negedge clk_i);
  endtask

  // Waits out owed bytes, then the longest result-free command (erase)
  // with margin, so a register write never lands mid-command.
  task automatic settle();
    start = 1'b0;
    while (sb.owed_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_packet_cap(input logic [RUN_W-1:0] v);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_cap(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [6:0] rand_accept();
    case ($urandom_range(7))
      0:       return 7'd0;
      1:       return 7'd64;
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // Random traffic built from short sequences: typed lines ending in CR or
  // LF (with edits), queue bursts, pump bursts, and a share of raw noise.
  task automatic drive_phase(input int n_items, input int pump_pct, input int idle_pct);
    in_t        c;
    int         sent;
    int         len;
    int         sel;
    logic       link;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(99);
      if (sel < pump_pct) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          c = mk_cmd(FUNC_PUMP, 8'($urandom), ($urandom_range(9) != 0), rand_accept());
          send_cmd(c, idle_pct);
          sent++;
        end
      end else if (sel < pump_pct + 45) begin
        // a typed line, trimmed to what is left of the phase
        len  = $urandom_range(1, LINE_DEPTH + 4);
        if (len > n_items - sent) len = n_items - sent;
        link = ($urandom_range(9) != 0);
        repeat (len) begin
          case ($urandom_range(9))
            0:       b = CH_BS;
            1:       b = CH_DEL;
            default: b = 8'($urandom_range(CH_SPACE, CH_TILDE));
          endcase
          c = mk_cmd(FUNC_RX, b, ($urandom_range(15) == 0) ? ~link : link, rand_accept());
          send_cmd(c, idle_pct);
          sent++;
        end
        c = mk_cmd(FUNC_RX, $urandom_range(1) ? CH_CR : CH_LF, link, rand_accept());
        send_cmd(c, idle_pct);
        sent++;
      end else if (sel < pump_pct + 70) begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          c = mk_cmd(FUNC_QUEUE, 8'($urandom), ($urandom_range(9) != 0), rand_accept());
          send_cmd(c, idle_pct);
          sent++;
        end
      end else begin
        // noise: any func, any byte (control chars, high bytes, func 3)
        c = mk_cmd(2'($urandom_range(3)), 8'($urandom), 1'($urandom), rand_accept());
        send_cmd(c, idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // cap above 64 must behave as 64
    write_packet_cap(7'd127);

    // Directed: empty-state corners first, then editing, link loss and
    // pump limits.
    send_cmd(mk_cmd(FUNC_PUMP, 8'h00, 1'b1, 7'd64), 0);   // empty ring
    send_cmd(mk_cmd(FUNC_RX, CH_BS, 1'b1, 7'd0), 0);      // erase on empty line
    send_cmd(mk_cmd(FUNC_RX, CH_CR, 1'b1, 7'd0), 0);      // empty line
    send_cmd(mk_cmd(FUNC_UNUSED, 8'hFF, 1'b1, 7'd64), 0); // unused func
    send_cmd(mk_cmd(FUNC_RX, CH_SPACE, 1'b1, 7'd0), 0);   // printable edges
    send_cmd(mk_cmd(FUNC_RX, CH_TILDE, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, 8'h41, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, 8'h1F, 1'b1, 7'd0), 0);      // ignored bytes
    send_cmd(mk_cmd(FUNC_RX, 8'h80, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, 8'hFF, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, 8'h00, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, CH_BS, 1'b1, 7'd0), 0);      // erase with echo
    send_cmd(mk_cmd(FUNC_RX, CH_DEL, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, 8'h62, 1'b0, 7'd0), 0);      // stored, echo lost
    send_cmd(mk_cmd(FUNC_QUEUE, 8'hFF, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_QUEUE, 8'h00, 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_QUEUE, 8'h55, 1'b0, 7'd0), 0);   // dropped, link down
    send_cmd(mk_cmd(FUNC_RX, CH_LF, 1'b0, 7'd0), 0);      // line still emitted
    send_cmd(mk_cmd(FUNC_PUMP, 8'h00, 1'b0, 7'd64), 0);   // link down: nothing
    send_cmd(mk_cmd(FUNC_PUMP, 8'h00, 1'b1, 7'd0), 0);    // accept 0: nothing
    send_cmd(mk_cmd(FUNC_PUMP, 8'h00, 1'b1, 7'd1), 0);
    send_cmd(mk_cmd(FUNC_PUMP, 8'h00, 1'b1, 7'd64), 0);
    send_cmd(mk_cmd(FUNC_RX, CH_CR, 1'b1, 7'd0), 0);
    // overlong line: the last character is refused, then the full line goes out
    repeat (LINE_DEPTH + 1)
      send_cmd(mk_cmd(FUNC_RX, 8'($urandom_range(CH_SPACE, CH_TILDE)), 1'b1, 7'd0), 0);
    send_cmd(mk_cmd(FUNC_RX, CH_CR, 1'b1, 7'd0), 0);
    settle();

    // Random phases; each cap change happens with the block idle.
    write_packet_cap(7'd64);
    drive_phase(40, 25, 30);
    settle();
    write_packet_cap(7'd1);
    drive_phase(30, 30, 50);
    settle();
    // cap 0: pumps send nothing, so the ring backs up
    write_packet_cap(7'd0);
    drive_phase(40, 5, 20);
    settle();
    // long runs drain the backlog
    write_packet_cap(7'd127);
    drive_phase(40, 40, 40);
    settle();
    write_packet_cap(7'($urandom_range(2, 63)));
    drive_phase(40, 25, 60);
    settle();
    write_packet_cap(7'd65);
    drive_phase(30, 25, 30);
    settle();
    // last stretch runs back to back
    write_packet_cap(7'd64);
    drive_phase(30, 25, 0);
    settle();

    $display("Checked %0d commands: %0d line bytes and %0d endpoint bytes.",
             sb.n_cmds, sb.n_line_bytes, sb.n_tx_bytes);
    $display("Ring drops on full: %0d, refused chars on full line: %0d, caps 0 to 127.",
             sb.n_drops, sb.n_line_full);
    if (sb.n_errors == 0 && sb.owed_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", sb.n_errors, sb.owed_bytes.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout guard against a hung run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d bytes still owed", sb.owed_bytes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
